FILE: rtl/fpadd_pkg.sv
// fpadd_pkg: shared constants, types and helpers for the binary32 adder
// no dependencies
package fpadd_pkg;

  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBits  = 8;
  localparam int unsigned WordBits = 32;
  // significand with hidden one, two guard bits and a sticky bit
  localparam int unsigned SigBits  = FracBits + 1;
  localparam int unsigned ExtBits  = SigBits + 3;
  localparam int unsigned SumBits  = ExtBits + 1;
  localparam int unsigned LzBits   = 5;

  localparam logic [WordBits-1:0] QnanBits = 32'h7FC0_0000;
  localparam logic [WordBits-1:0] InfMag   = 32'h7F80_0000;
  localparam logic [ExpBits-1:0]  ExpMax   = 8'hFF;

  // special-case outcome, decided in the first stage or, for a zero sum, in stage 3
  typedef enum logic [2:0] {
    SPC_NONE = 3'b001,
    SPC_PASS = 3'b010,
    SPC_FIX  = 3'b100
  } spc_t;

  // stage 1 -> stage 2: ordered operands
  typedef struct packed {
    spc_t                spc;
    logic [WordBits-1:0] fixed;
    logic                sign;
    logic                sub;
    logic [ExpBits-1:0]  exp;
    logic [ExpBits-1:0]  diff;
    logic [SigBits-1:0]  sig_a;
    logic [SigBits-1:0]  sig_b;
  } s1_t;

  // stage 2 -> stage 3: raw sum
  typedef struct packed {
    spc_t                spc;
    logic [WordBits-1:0] fixed;
    logic                sign;
    logic [ExpBits-1:0]  exp;
    logic [SumBits-1:0]  sum;
  } s2_t;

  // stage 3 -> stage 4: normalized value
  typedef struct packed {
    spc_t                spc;
    logic [WordBits-1:0] fixed;
    logic                sign;
    logic signed [ExpBits+1:0] exp;
    logic [ExtBits-1:0]  norm;
  } s3_t;

  // leading zero count of the sum below its carry bit
  function automatic logic [LzBits-1:0] lead_zeros(input logic [ExtBits-1:0] v);
    logic [LzBits-1:0] n;
    logic              hit;
    n   = LzBits'(ExtBits);
    hit = 1'b0;
    for (int i = ExtBits - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = LzBits'(ExtBits - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/fp32_adder.sv
// fp32_adder: top level of the binary32 adder with valid/ready channels
// depends on fpadd_pkg and fpadd_core
//
// usage:
//   input channel in_valid/in_ready carries in_operand_a and in_operand_b,
//   result channel out_valid/out_ready carries out_sum_bits (round to
//   nearest even, denormals flushed to zero, canonical quiet NaN).
//   out_valid rises once a request has passed all four register stages
//   (unpack and order, align and add, normalize, round and pack); one
//   request is taken every cycle while out_ready stays high, as each
//   stage holds one request.
//   in_ready is high whenever the last stage is empty or being drained.
//   when out_ready is low with a result waiting, the whole pipeline holds,
//   bubbles included, and in_ready stays low; nothing is lost or repeated.
//   reset clears all valid bits; the data registers are not reset.
module fp32_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_bits
);

  logic adv;

  // advance when the output stage is free or being taken
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  fpadd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .a       (in_operand_a),
    .b       (in_operand_b),
    .out_vld (out_valid),
    .res     (out_sum_bits)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_bits))
    else $error("result dropped while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
`endif

endmodule

FILE: rtl/fpadd_core.sv
// fpadd_core: four-stage datapath of the adder (unpack, align/add, normalize, round)
// depends on fpadd_pkg; stall enable comes from the top level
module fpadd_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] res
);

  localparam int unsigned FB = fpadd_pkg::FracBits;
  localparam int unsigned EB = fpadd_pkg::ExpBits;
  localparam int unsigned SB = fpadd_pkg::SigBits;
  localparam int unsigned XB = fpadd_pkg::ExtBits;
  localparam int unsigned UB = fpadd_pkg::SumBits;

  logic [3:0] vld_r;
  fpadd_pkg::s1_t s1_r, s1_nxt;
  fpadd_pkg::s2_t s2_r, s2_nxt;
  fpadd_pkg::s3_t s3_r, s3_nxt;
  logic [31:0] res_r, res_nxt;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // stage 1: specials, flush denormals, order by magnitude
  always_comb begin
    logic [EB-1:0] ea, eb;
    logic [30:0]   ma, mb;
    logic [31:0]   x, y;
    logic          nan_a, nan_b;
    ea = a[30:23];
    eb = b[30:23];
    nan_a = (ea == fpadd_pkg::ExpMax) && (a[FB-1:0] != '0);
    nan_b = (eb == fpadd_pkg::ExpMax) && (b[FB-1:0] != '0);
    ma = (ea == '0) ? '0 : a[30:0];
    mb = (eb == '0) ? '0 : b[30:0];
    s1_nxt = '0;
    s1_nxt.spc = fpadd_pkg::SPC_NONE;
    if (nan_a || nan_b) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = fpadd_pkg::QnanBits;
    end else if (ea == fpadd_pkg::ExpMax && eb == fpadd_pkg::ExpMax) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = (a[31] ^ b[31]) ? fpadd_pkg::QnanBits : a;
    end else if (ea == fpadd_pkg::ExpMax) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = a;
    end else if (eb == fpadd_pkg::ExpMax) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = b;
    end else if (ma == '0 && mb == '0) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = {a[31] & b[31], 31'd0};
    end else if (ma == '0) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = b;
    end else if (mb == '0) begin
      s1_nxt.spc = fpadd_pkg::SPC_FIX;
      s1_nxt.fixed = a;
    end
    if (ma < mb) begin
      x = {b[31], mb};
      y = {a[31], ma};
    end else begin
      x = {a[31], ma};
      y = {b[31], mb};
    end
    s1_nxt.sign  = x[31];
    s1_nxt.sub   = x[31] ^ y[31];
    s1_nxt.exp   = x[30:23];
    s1_nxt.diff  = x[30:23] - y[30:23];
    s1_nxt.sig_a = {1'b1, x[FB-1:0]};
    s1_nxt.sig_b = {1'b1, y[FB-1:0]};
  end

  // stage 2: align smaller significand with sticky, then add or subtract
  always_comb begin
    logic [2*XB-1:0] wide;
    logic [XB-1:0]   al;
    logic [XB-1:0]   va;
    wide = {s1_r.sig_b, 3'b000, {XB{1'b0}}} >> s1_r.diff;
    if (s1_r.diff >= EB'(XB)) begin
      al = XB'(1);
    end else begin
      al = wide[2*XB-1:XB] | XB'(wide[XB-1:0] != '0);
    end
    va = {s1_r.sig_a, 3'b000};
    s2_nxt.spc   = s1_r.spc;
    s2_nxt.fixed = s1_r.fixed;
    s2_nxt.sign  = s1_r.sign;
    s2_nxt.exp   = s1_r.exp;
    s2_nxt.sum   = s1_r.sub ? ({1'b0, va} - {1'b0, al}) : ({1'b0, va} + {1'b0, al});
  end

  // stage 3: normalize so the leading one lands at the top of the field
  always_comb begin
    logic [fpadd_pkg::LzBits-1:0] lz;
    s3_nxt.spc   = s2_r.spc;
    s3_nxt.fixed = s2_r.fixed;
    s3_nxt.sign  = s2_r.sign;
    lz = fpadd_pkg::lead_zeros(s2_r.sum[XB-1:0]);
    if (s2_r.sum[UB-1]) begin
      s3_nxt.norm = s2_r.sum[UB-1:1] | XB'(s2_r.sum[0]);
      s3_nxt.exp  = $signed({2'b00, s2_r.exp}) + 10'sd1;
    end else begin
      s3_nxt.norm = s2_r.sum[XB-1:0] << lz;
      s3_nxt.exp  = $signed({2'b00, s2_r.exp}) - $signed({5'd0, lz});
    end
    if (s2_r.spc == fpadd_pkg::SPC_NONE && s2_r.sum == '0) begin
      s3_nxt.spc   = fpadd_pkg::SPC_FIX;
      s3_nxt.fixed = '0;
    end
  end

  // stage 4: round to nearest even, overflow to infinity, underflow flush; specials pass through
  always_comb begin
    logic [SB:0] rnd;
    logic        up;
    logic signed [EB+1:0] e;
    up  = s3_r.norm[2] && (s3_r.norm[1] || s3_r.norm[0] || s3_r.norm[3]);
    rnd = {1'b0, s3_r.norm[XB-1:3]} + (SB+1)'(up);
    e   = s3_r.exp;
    if (rnd[SB]) begin
      rnd = rnd >> 1;
      e   = e + 10'sd1;
    end
    if (s3_r.spc != fpadd_pkg::SPC_NONE) begin
      res_nxt = s3_r.fixed;
    end else if (e >= 10'sd255) begin
      res_nxt = {s3_r.sign, 31'd0} | fpadd_pkg::InfMag;
    end else if (e <= 10'sd0) begin
      res_nxt = {s3_r.sign, 31'd0};
    end else begin
      res_nxt = {s3_r.sign, e[EB-1:0], rnd[FB-1:0]};
    end
  end

  // pipeline registers, all held while the output waits
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r[3];
  assign res     = res_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(res_r))
    else $error("pipeline moved during stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[2] |=> vld_r[3])
    else $error("valid lost between stages 3 and 4");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[2] && s3_r.spc == fpadd_pkg::SPC_FIX |=> res_r == $past(s3_r.fixed))
    else $error("special result not passed through");
`endif

endmodule
